/* design/plt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plt_pkg
// Shared widths, codes and transfer types of the piecewise linear
// interpolation table.
// ----------------------------------------------------------------------------
package plt_pkg;

    localparam int unsigned VALUE_BITS      = 48;
    // differences of two values need one more bit
    localparam int unsigned DIFF_W          = VALUE_BITS + 1;
    localparam int unsigned MAX_ENTRIES_DEF = 32;
    localparam int unsigned CFG_W           = 6;
    localparam int unsigned INDEX_W         = 5;
    localparam int unsigned STATUS_W        = 2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSIDE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FIRST  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LAST   = 2'd2;

    typedef struct packed {
        logic                          operation;
        logic [INDEX_W-1:0]            entry_index;
        logic signed [VALUE_BITS-1:0]  entry_key;
        logic signed [VALUE_BITS-1:0]  entry_value;
        logic signed [VALUE_BITS-1:0]  query_key;
    } t_plt_in;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0]  interp_value;
        logic [STATUS_W-1:0]           clamp_status;
    } t_plt_out;

endpackage
`default_nettype wire

/* design/plt_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plt_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module plt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* design/plt_muldiv.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plt_muldiv
// Unsigned (a*b)/d: four half-width partial products accumulated in turn,
// then a restoring division one quotient bit per cycle.
// The quotient must fit DIFF_W bits, i.e. a*b < d * 2**DIFF_W.
// ----------------------------------------------------------------------------
module plt_muldiv
    import plt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIFF_W-1:0] i_mcand,
    input  wire logic [DIFF_W-1:0] i_mplier,
    input  wire logic [DIFF_W-1:0] i_divisor,
    output logic                   o_done,
    output logic      [DIFF_W-1:0] o_quot
);

    localparam int unsigned HW   = (DIFF_W + 1) / 2;
    localparam int unsigned PW   = 2 * DIFF_W;
    localparam int unsigned CW   = ($clog2(DIFF_W + 1) > 3) ? $clog2(DIFF_W + 1) : 3;
    localparam int unsigned MUL_LAST = 4;

    typedef enum logic [1:0] {
        M_IDLE,
        M_MUL,
        M_DIV
    } t_mstate;

    t_mstate            r_state;
    logic [CW-1:0]      r_cnt;
    logic [2*HW-1:0]    r_pp;
    logic [1:0]         r_pp_sel;
    logic [PW-1:0]      r_acc;
    logic [DIFF_W-1:0]  r_rem;
    logic [DIFF_W-1:0]  r_lo;
    logic               r_done;

    logic [HW-1:0]      a_lo, a_hi, b_lo, b_hi, a_sel, b_sel;
    logic [2*HW-1:0]    pp;
    logic [PW-1:0]      pp_placed;
    logic [PW-1:0]      acc_sum;
    logic [DIFF_W:0]    trial;
    logic               ge;
    logic [DIFF_W:0]    trial_diff;

    always_comb begin
        a_lo  = i_mcand[HW-1:0];
        a_hi  = HW'(i_mcand[DIFF_W-1:HW]);
        b_lo  = i_mplier[HW-1:0];
        b_hi  = HW'(i_mplier[DIFF_W-1:HW]);
        a_sel = r_cnt[1] ? a_hi : a_lo;
        b_sel = r_cnt[0] ? b_hi : b_lo;
        pp    = a_sel * b_sel;

        case (r_pp_sel)
            2'd0:    pp_placed = PW'(r_pp);
            2'd1,
            2'd2:    pp_placed = PW'(r_pp) << HW;
            2'd3:    pp_placed = PW'(r_pp) << (2 * HW);
            default: pp_placed = '0;
        endcase
        acc_sum = r_acc + pp_placed;

        trial      = {r_rem, r_lo[DIFF_W-1]};
        ge         = (trial >= {1'b0, i_divisor});
        trial_diff = trial - {1'b0, i_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_cnt   <= '0;
                        r_acc   <= '0;
                        r_state <= M_MUL;
                    end
                end
                M_MUL: begin
                    r_pp     <= pp;
                    r_pp_sel <= r_cnt[1:0];
                    // the previous cycle's partial product is summed here
                    if (r_cnt != '0) begin
                        r_acc <= acc_sum;
                    end
                    if (r_cnt == CW'(MUL_LAST)) begin
                        r_rem   <= acc_sum[PW-1:DIFF_W];
                        r_lo    <= acc_sum[DIFF_W-1:0];
                        r_cnt   <= '0;
                        r_state <= M_DIV;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                M_DIV: begin
                    r_rem <= ge ? trial_diff[DIFF_W-1:0] : trial[DIFF_W-1:0];
                    r_lo  <= {r_lo[DIFF_W-2:0], ge};
                    if (r_cnt == CW'(DIFF_W - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= M_IDLE;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quot = r_lo;

endmodule
`default_nettype wire

/* design/piecewise_linear_table_interp.sv */
`timescale 1ns / 1ps
`default_nettype none
// A write transfer leaves busy low; one query is in flight at a time. A query checks entry 0
// for a first-entry clamp, then the last entry for a last-entry clamp, else scans for entries
// u-1 and u and interpolates between them (scan, partial products, then quotient bits).
// Busy falls with the strobe. The strobe lasts one cycle and cannot be held off; a new query
// can be taken while the strobe is high.
// Synchronous reset sets r_entries to 1; table contents are undefined until written.
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp
// Breakpoint table in two RAMs with a linear search and an interpolating
// multiply/divide unit.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interp
    import plt_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire t_plt_in          i_in,
    output logic                  o_strobe,
    output t_plt_out              o_out,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_wdata
);

    localparam int unsigned AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned NW  = ($clog2(MAX_ENTRIES + 1) > CFG_W) ?
                                  $clog2(MAX_ENTRIES + 1) : CFG_W;
    localparam int unsigned IW  = ((AW + 1) > INDEX_W) ? (AW + 1) : INDEX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST_RD,
        S_FIRST_CHK,
        S_LAST_CHK,
        S_SCAN,
        S_PREP,
        S_ARITH
    } t_state;

    t_state                       r_state;
    logic [CFG_W-1:0]             r_entries;
    logic [AW-1:0]                r_addr;
    logic signed [VALUE_BITS-1:0] r_key;
    logic signed [VALUE_BITS-1:0] r_x0, r_y0, r_x1, r_y1;
    logic [DIFF_W-1:0]            r_dx, r_den, r_dy;
    logic                         r_up;
    logic                         r_md_start;
    logic                         r_strobe;
    t_plt_out                     r_out;

    logic                         accept;
    logic [IW-1:0]                widx;
    logic                         ram_we;
    logic [NW-1:0]                n_used;
    logic [NW-1:0]                last_full;
    logic [AW-1:0]                last_idx;
    logic signed [VALUE_BITS-1:0] key_rd, val_rd;
    logic signed [DIFF_W-1:0]     dy_diff;
    logic                         md_done;
    logic [DIFF_W-1:0]            md_quot;
    logic [DIFF_W-1:0]            q_lim;
    logic [DIFF_W-1:0]            res_sum;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign widx   = IW'(i_in.entry_index);
    assign ram_we = accept && (i_in.operation == OP_WRITE) &&
                    (widx < IW'(MAX_ENTRIES));

    // entries searched, clamped to 1..MAX_ENTRIES
    always_comb begin
        n_used = NW'(r_entries);
        if (n_used == '0) begin
            n_used = NW'(1);
        end else if (n_used > NW'(MAX_ENTRIES)) begin
            n_used = NW'(MAX_ENTRIES);
        end
        last_full = n_used - NW'(1);
    end
    assign last_idx = last_full[AW-1:0];

    plt_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_ENTRIES)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (widx[AW-1:0]),
        .i_wdata (i_in.entry_key),
        .i_raddr (r_addr),
        .o_rdata (key_rd)
    );

    plt_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_ENTRIES)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (widx[AW-1:0]),
        .i_wdata (i_in.entry_value),
        .i_raddr (r_addr),
        .o_rdata (val_rd)
    );

    plt_muldiv u_muldiv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_md_start),
        .i_mcand   (r_dy),
        .i_mplier  (r_dx),
        .i_divisor (r_den),
        .o_done    (md_done),
        .o_quot    (md_quot)
    );

    always_comb begin
        dy_diff = {r_y1[VALUE_BITS-1], r_y1} - {r_y0[VALUE_BITS-1], r_y0};
        q_lim   = (md_quot > r_dy) ? r_dy : md_quot;
        res_sum = r_up ? ({r_y0[VALUE_BITS-1], r_y0} + q_lim)
                       : ({r_y0[VALUE_BITS-1], r_y0} - q_lim);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_entries  <= CFG_W'(1);
            r_strobe   <= 1'b0;
            r_md_start <= 1'b0;
        end else begin
            r_strobe   <= 1'b0;
            r_md_start <= 1'b0;
            if (i_cfg_we) begin
                r_entries <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept && (i_in.operation == OP_QUERY)) begin
                        r_key   <= i_in.query_key;
                        r_addr  <= '0;
                        r_state <= S_FIRST_RD;
                    end
                end
                S_FIRST_RD: begin
                    r_addr  <= last_idx;
                    r_state <= S_FIRST_CHK;
                end
                S_FIRST_CHK: begin
                    // entry zero on the read port
                    if (r_key <= key_rd) begin
                        r_out.interp_value <= val_rd;
                        r_out.clamp_status <= ST_FIRST;
                        r_strobe           <= 1'b1;
                        r_state            <= S_IDLE;
                    end else begin
                        r_x0    <= key_rd;
                        r_y0    <= val_rd;
                        r_addr  <= AW'(1);
                        r_state <= S_LAST_CHK;
                    end
                end
                S_LAST_CHK: begin
                    if (r_key >= key_rd) begin
                        r_out.interp_value <= val_rd;
                        r_out.clamp_status <= ST_LAST;
                        r_strobe           <= 1'b1;
                        r_state            <= S_IDLE;
                    end else begin
                        r_addr  <= r_addr + AW'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // read data belongs to r_addr - 1; the last entry always stops the scan
                    if (key_rd > r_key) begin
                        r_x1    <= key_rd;
                        r_y1    <= val_rd;
                        r_state <= S_PREP;
                    end else begin
                        r_x0   <= key_rd;
                        r_y0   <= val_rd;
                        r_addr <= r_addr + AW'(1);
                    end
                end
                S_PREP: begin
                    r_dx       <= {r_key[VALUE_BITS-1], r_key} - {r_x0[VALUE_BITS-1], r_x0};
                    r_den      <= {r_x1[VALUE_BITS-1], r_x1} - {r_x0[VALUE_BITS-1], r_x0};
                    r_up       <= (r_y1 >= r_y0);
                    r_dy       <= (r_y1 >= r_y0) ? DIFF_W'(dy_diff) : DIFF_W'(-dy_diff);
                    r_md_start <= 1'b1;
                    r_state    <= S_ARITH;
                end
                S_ARITH: begin
                    if (md_done) begin
                        r_out.interp_value <= res_sum[VALUE_BITS-1:0];
                        r_out.clamp_status <= ST_INSIDE;
                        r_strobe           <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_out    = r_out;

endmodule
`default_nettype wire
